>>> design/integer_sort_ascending_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer sort unit
// Shared assertion wrappers; each expands to one labeled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef INTEGER_SORT_ASCENDING_UNIT_MACROS_SVH
`define INTEGER_SORT_ASCENDING_UNIT_MACROS_SVH

// Check a property on every rising edge outside reset
`define ISAU_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define ISAU_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

>>> design/isau_pkg.sv
// ----------------------------------------------------------------------------
// Integer sort unit package
// Widths, defaults and the control word shared by the cell chain.
// ----------------------------------------------------------------------------
package isau_pkg;

  localparam int unsigned VALUE_W           = 32;
  localparam int unsigned DEFAULT_MAX_ITEMS = 64;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;  // place the broadcast key into the sorted row
    logic shift;   // move every word one cell toward the output
  } cell_ctrl_t;

endpackage

>>> design/isau_cell.sv
// ----------------------------------------------------------------------------
// Insertion cell
// Holds one word of the sorted row. On insert it keeps its word, takes the
// word of its left neighbor, or takes the key; on shift it takes the word of
// its right neighbor.
// ----------------------------------------------------------------------------
module isau_cell (
  input  logic                                clk_i,
  input  isau_pkg::cell_ctrl_t                ctrl_i,
  input  logic                                empty_i,     // cell beyond fill level
  input  logic signed [isau_pkg::VALUE_W-1:0] key_i,
  input  logic signed [isau_pkg::VALUE_W-1:0] left_val_i,
  input  logic                                left_lt_i,   // key goes at or before left cell
  input  logic signed [isau_pkg::VALUE_W-1:0] right_val_i,
  output logic signed [isau_pkg::VALUE_W-1:0] val_o,
  output logic                                lt_o         // key goes at or before this cell
);
  import isau_pkg::*;

  logic signed [VALUE_W-1:0] val_q, val_d;

  // Key sorts ahead of this cell; an empty cell acts as plus infinity
  assign lt_o = empty_i | (key_i < val_q);

  // Select the next word
  always_comb begin
    val_d = val_q;
    if (ctrl_i.shift) begin
      val_d = right_val_i;
    end else if (ctrl_i.insert && lt_o) begin
      val_d = left_lt_i ? left_val_i : key_i;
    end
  end

  // Hold the word
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

>>> design/integer_sort_ascending_unit.sv
// After the tlast item the first sorted word is offered on the next cycle,
// then one word per cycle while m_axis_tready is high.
// Throughput: one input word per cycle while loading (one compare per cell);
// no input is taken while the stored words drain.
// Reset clears the fill count, overflow flag and state; cell words are
// undefined until loaded and only filled cells reach the output.
// ----------------------------------------------------------------------------
// Integer sort unit, top level
// Systolic insertion chain: words are inserted in sorted place as they
// arrive and shifted out in ascending signed order on the last word.
// ----------------------------------------------------------------------------
`include "integer_sort_ascending_unit_macros.svh"

module integer_sort_ascending_unit #(
  parameter int unsigned MAX_ITEMS = isau_pkg::DEFAULT_MAX_ITEMS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] value_res
  output logic        m_axis_tlast,   // last_res
  output logic        m_axis_tuser    // [0] overflow
);
  import isau_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;

  logic             in_fire, out_fire, full;
  cell_ctrl_t       ctrl;

  logic signed [VALUE_W-1:0] key;
  logic signed [VALUE_W-1:0] vals [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]      lts;

  assign key      = $signed(s_axis_tdata[VALUE_W-1:0]);
  assign full     = (count_q == CNT_W'(MAX_ITEMS));
  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign out_fire = m_axis_tvalid & m_axis_tready;

  assign ctrl.insert = in_fire & ~full;
  assign ctrl.shift  = out_fire;

  // Build the chain
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_val, right_val;
    logic                      left_lt;

    if (i == 0) begin : g_head
      assign left_val = '0;
      assign left_lt  = 1'b0;
    end else begin : g_body
      assign left_val = vals[i-1];
      assign left_lt  = lts[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_inner
      assign right_val = vals[i+1];
    end

    isau_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .empty_i     (count_q <= CNT_W'(i)),
      .key_i       (key),
      .left_val_i  (left_val),
      .left_lt_i   (left_lt),
      .right_val_i (right_val),
      .val_o       (vals[i]),
      .lt_o        (lts[i])
    );
  end

  // Sequence load and drain
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
          if (s_axis_tlast) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_fire) begin
          count_d = count_q - CNT_W'(1);
          if (count_q == CNT_W'(1)) begin
            state_d = ST_LOAD;
            ovf_d   = 1'b0;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  assign s_axis_tready = (state_q == ST_LOAD);
  assign m_axis_tvalid = (state_q == ST_DRAIN);
  assign m_axis_tdata  = vals[0];
  assign m_axis_tlast  = (count_q == CNT_W'(1));
  assign m_axis_tuser  = ovf_q;

  // Checks
  `ISAU_ASSERT_NEVER(a_no_overlap, clk_i, rst_ni, s_axis_tready && m_axis_tvalid, "load and drain overlap")
  `ISAU_ASSERT(a_last_starts_drain, clk_i, rst_ni, in_fire && s_axis_tlast |=> m_axis_tvalid, "tlast did not start drain")
  `ISAU_ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CNT_W'(MAX_ITEMS), "fill count beyond capacity")
  `ISAU_ASSERT_NEVER(a_drain_nonempty, clk_i, rst_ni, m_axis_tvalid && (count_q == '0), "drain with empty row")
  `ISAU_ASSERT(a_ascending, clk_i, rst_ni, out_fire && !m_axis_tlast |=> !($signed(m_axis_tdata) < $signed($past(m_axis_tdata))), "output not ascending")

endmodule
